// File: sv/bwdl_pkg.sv
// bwdl_pkg: shared types and constants for the bus watch with dirty log
// no dependencies
package bwdl_pkg;

  localparam int unsigned LogDepthDefault = 64;
  localparam int unsigned AddrBitsDefault = 16;

  localparam logic [7:0] AttrRo     = 8'h01;
  localparam logic [7:0] AttrBp     = 8'h04;
  localparam logic [7:0] AttrUninit = 8'h80;

  typedef enum logic [2:0] {
    OP_BUS  = 3'd0,
    OP_LOAD = 3'd1,
    OP_HDAT = 3'd2,
    OP_TICK = 3'd3,
    OP_BEGIN = 3'd4
  } op_e;

  typedef enum logic [0:0] {
    REG_EXIT_EN = 1'b0,
    REG_PERIOD  = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_COMMIT,
    ST_DECIDE,
    ST_REPORT,
    ST_ACK
  } state_e;

  // log lookup request/result between top and log module
  typedef struct packed {
    logic search;   // start a match scan
    logic commit;   // write entry found/appended
    logic clear;    // empty the log
  } log_ctl_t;

  typedef struct packed {
    logic done;
    logic hit;
  } log_stat_t;

endpackage

// File: sv/bwdl_store.sv
// bwdl_store: attribute and data memories, registered read
// depends on bwdl_pkg
module bwdl_store #(
  parameter int unsigned AddrBits = bwdl_pkg::AddrBitsDefault
) (
  input  logic                clk_i,
  input  logic [AddrBits-1:0] addr_i,
  input  logic                attr_we_i,
  input  logic [7:0]          attr_wd_i,
  input  logic                data_we_i,
  input  logic [7:0]          data_wd_i,
  output logic [7:0]          attr_rd_o,
  output logic [7:0]          data_rd_o
);
  logic [7:0] attr_mem [2**AddrBits];
  logic [7:0] data_mem [2**AddrBits];

  always_ff @(posedge clk_i) begin
    if (attr_we_i) attr_mem[addr_i] <= attr_wd_i;
    attr_rd_o <= attr_mem[addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (data_we_i) data_mem[addr_i] <= data_wd_i;
    data_rd_o <= data_mem[addr_i];
  end
endmodule

// File: sv/bwdl_log.sv
// bwdl_log: dirty write log, address match scan over a registered memory
// depends on bwdl_pkg
module bwdl_log #(
  parameter int unsigned LogDepth = bwdl_pkg::LogDepthDefault,
  parameter int unsigned AddrBits = bwdl_pkg::AddrBitsDefault,
  localparam int unsigned IdxW = $clog2(LogDepth),
  localparam int unsigned CntW = $clog2(LogDepth + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bwdl_pkg::log_ctl_t   ctl_i,
  input  logic [AddrBits-1:0]  addr_i,
  input  logic [7:0]           data_i,
  input  logic [IdxW-1:0]      rd_idx_i,
  output bwdl_pkg::log_stat_t  stat_o,
  output logic [CntW-1:0]      fill_o,
  output logic [AddrBits-1:0]  rd_addr_o,
  output logic [7:0]           rd_data_o
);
  logic [AddrBits-1:0] addr_mem [LogDepth];
  logic [7:0]          val_mem  [LogDepth];
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] scan_q, scan_d;
  logic            busy_q, busy_d;
  logic            pend_q, pend_d;   // a read is in flight
  logic            hit_q, hit_d;
  logic [IdxW-1:0] hidx_q, hidx_d;
  logic [IdxW-1:0] ridx;
  logic [AddrBits-1:0] mem_a_q;
  logic [7:0]          mem_v_q;
  logic [IdxW-1:0]     pidx_q;
  logic                we;
  logic [IdxW-1:0]     widx;
  logic                match, found, scan_end;

  // scanning reads entries in turn; otherwise the report index
  assign ridx = busy_q ? scan_q[IdxW-1:0] : rd_idx_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      addr_mem[widx] <= addr_i;
      val_mem[widx]  <= data_i;
    end
    mem_a_q <= addr_mem[ridx];
    mem_v_q <= val_mem[ridx];
  end
  assign rd_addr_o = mem_a_q;
  assign rd_data_o = mem_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      scan_q <= '0;
      busy_q <= 1'b0;
      pend_q <= 1'b0;
      hit_q  <= 1'b0;
      hidx_q <= '0;
      pidx_q <= '0;
    end else begin
      fill_q <= fill_d;
      scan_q <= scan_d;
      busy_q <= busy_d;
      pend_q <= pend_d;
      hit_q  <= hit_d;
      hidx_q <= hidx_d;
      pidx_q <= ridx;
    end
  end

  // compare the entry that came back from last cycle's read
  assign match    = pend_q && (mem_a_q == addr_i);
  assign found    = hit_q || match;
  assign scan_end = busy_q && (found || scan_q >= fill_q);

  always_comb begin
    stat_o.done = scan_end;
    stat_o.hit  = found;
  end

  always_comb begin
    fill_d = fill_q;
    scan_d = scan_q;
    busy_d = busy_q;
    pend_d = 1'b0;
    hit_d  = hit_q;
    hidx_d = hidx_q;
    we     = 1'b0;
    widx   = hit_q ? hidx_q : fill_q[IdxW-1:0];
    if (ctl_i.clear) begin
      fill_d = '0;
      busy_d = 1'b0;
    end else if (ctl_i.search) begin
      scan_d = '0;
      hit_d  = 1'b0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (match && !hit_q) begin
        hit_d  = 1'b1;
        hidx_d = pidx_q;
      end
      if (scan_end) begin
        busy_d = 1'b0;
      end else begin
        scan_d = scan_q + 1'b1;
        pend_d = 1'b1;
      end
    end
    if (ctl_i.commit) begin
      if (hit_q) begin
        we = 1'b1;
      end else if (fill_q < CntW'(LogDepth)) begin
        we = 1'b1;
        fill_d = fill_q + 1'b1;
      end
    end
  end
  assign fill_o = fill_q;
endmodule

// File: sv/bus_watch_with_dirty_log_unit.sv
// bus_watch_with_dirty_log_unit: top level of the bus watch with dirty log
// depends on bwdl_pkg, bwdl_store, bwdl_log
//
// usage: raise start with an item on operation_i..bus_read_i while busy is
// low. results come out one per cycle on the result ports, marked by
// result_valid_o; last_o marks the final one of an item. the receiver cannot
// stall, results are simply taken as shown.
// a host load, host data write, tick, begin or unknown operation goes from the
// read state to the acknowledge state; busy drops in the cycle after.
// a bus read or an invalid bus cycle adds a count/report decision state between
// the read state and the result. a bus write scans the log one entry a cycle
// for an address match, stopping at the first match or at the fill, then
// commits before the decision state. a report replaces the acknowledge with
// one result per log entry (one result when the log is empty), one cycle each,
// fed from the log read port. registers are written through the apb port;
// the user writes them only while the block is idle, which the block does not
// enforce. reset clears the control state, counters, exit bits and the log
// fill; the stores hold whatever was last written and need no clearing.
module bus_watch_with_dirty_log_unit #(
  parameter int unsigned LogDepth = bwdl_pkg::LogDepthDefault,
  parameter int unsigned AddrBits = bwdl_pkg::AddrBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  data_i,
  input  logic [7:0]  attributes_i,
  input  logic        bus_valid_i,
  input  logic        bus_read_i,
  output logic        result_valid_o,
  output logic        kind_o,
  output logic [7:0]  read_data_o,
  output logic [7:0]  exit_code_o,
  output logic [15:0] report_address_o,
  output logic [15:0] cycle_total_o,
  output logic [6:0]  log_count_o,
  output logic [15:0] entry_address_o,
  output logic [7:0]  entry_data_o,
  output logic        entry_valid_o,
  output logic        last_o
);
  localparam int unsigned IdxW = $clog2(LogDepth);
  localparam int unsigned CntW = $clog2(LogDepth + 1);

  bwdl_pkg::state_e state_q, state_d;
  logic [7:0]  exit_en_q, exit_en_d;
  logic [15:0] period_q, period_d;
  logic [2:0]  op_q;
  logic [AddrBits-1:0] addr_q;
  logic [7:0]  dat_q, attr_q;
  logic        valid_q, rd_q;
  logic [7:0]  exit_q, exit_d;
  logic [15:0] cyc_q, cyc_d;
  logic [AddrBits-1:0] lba_q, lba_d;
  logic [15:0] tick_q, tick_d;
  logic        tpend_q, tpend_d;
  logic [7:0]  rdat_q, rdat_d;
  logic [IdxW-1:0] ridx_q, ridx_d;
  logic [15:0] tick_inc;

  logic        attr_we, data_we;
  logic [7:0]  attr_wd, data_wd, attr_rd, data_rd;
  bwdl_pkg::log_ctl_t  lctl;
  bwdl_pkg::log_stat_t lstat;
  logic [CntW-1:0]     fill;
  logic [AddrBits-1:0] log_a;
  logic [7:0]          log_v;
  logic                cfg_wr, accept;
  logic                last_entry, rep_done;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      bwdl_pkg::REG_EXIT_EN: prdata = {24'd0, exit_en_q};
      bwdl_pkg::REG_PERIOD:  prdata = {16'd0, period_q};
      default:               prdata = '0;
    endcase
  end
  always_comb begin
    exit_en_d = exit_en_q;
    period_d  = period_q;
    if (cfg_wr) begin
      if (paddr[2] == bwdl_pkg::REG_EXIT_EN) exit_en_d = pwdata[7:0];
      else period_d = pwdata[15:0];
    end
  end

  assign busy   = (state_q != bwdl_pkg::ST_IDLE);
  assign accept = start && !busy;

  bwdl_store #(.AddrBits(AddrBits)) u_store (
    .clk_i, .addr_i(accept ? address_i[AddrBits-1:0] : addr_q),
    .attr_we_i(attr_we), .attr_wd_i(attr_wd),
    .data_we_i(data_we), .data_wd_i(data_wd),
    .attr_rd_o(attr_rd), .data_rd_o(data_rd)
  );

  bwdl_log #(.LogDepth(LogDepth), .AddrBits(AddrBits)) u_log (
    .clk_i, .rst_ni, .ctl_i(lctl), .addr_i(addr_q), .data_i(dat_q),
    .rd_idx_i(ridx_d), .stat_o(lstat), .fill_o(fill),
    .rd_addr_o(log_a), .rd_data_o(log_v)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= operation_i;
      addr_q  <= address_i[AddrBits-1:0];
      dat_q   <= data_i;
      attr_q  <= attributes_i;
      valid_q <= bus_valid_i;
      rd_q    <= bus_read_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bwdl_pkg::ST_IDLE;
      exit_en_q <= '0;
      period_q  <= '0;
      exit_q    <= '0;
      cyc_q     <= '0;
      lba_q     <= '0;
      tick_q    <= '0;
      tpend_q   <= 1'b0;
      rdat_q    <= '0;
      ridx_q    <= '0;
    end else begin
      state_q   <= state_d;
      exit_en_q <= exit_en_d;
      period_q  <= period_d;
      exit_q    <= exit_d;
      cyc_q     <= cyc_d;
      lba_q     <= lba_d;
      tick_q    <= tick_d;
      tpend_q   <= tpend_d;
      rdat_q    <= rdat_d;
      ridx_q    <= ridx_d;
    end
  end

  assign tick_inc   = tick_q + 16'd1;
  assign last_entry = (CntW'(ridx_q) + CntW'(1)) == fill;
  // an empty log still reports with one item
  assign rep_done   = (fill == CntW'(0)) || last_entry;

  always_comb begin
    state_d = state_q;
    exit_d  = exit_q;
    cyc_d   = cyc_q;
    lba_d   = lba_q;
    tick_d  = tick_q;
    tpend_d = tpend_q;
    rdat_d  = rdat_q;
    ridx_d  = ridx_q;
    attr_we = 1'b0;
    attr_wd = attr_q;
    data_we = 1'b0;
    data_wd = dat_q;
    lctl    = '0;
    result_valid_o  = 1'b0;
    kind_o          = 1'b0;
    entry_valid_o   = 1'b0;
    entry_address_o = '0;
    entry_data_o    = '0;
    last_o          = 1'b1;
    unique case (state_q)
      bwdl_pkg::ST_IDLE: begin
        if (accept) begin
          rdat_d  = '0;
          state_d = bwdl_pkg::ST_READ;
        end
      end
      bwdl_pkg::ST_READ: begin
        // store read data for addr_q is valid in this cycle
        state_d = bwdl_pkg::ST_ACK;
        unique case (op_q)
          bwdl_pkg::OP_LOAD: begin
            attr_we = 1'b1;
            data_we = 1'b1;
            data_wd = (attr_q & bwdl_pkg::AttrUninit) != 8'd0 ? 8'd0 : dat_q;
          end
          bwdl_pkg::OP_HDAT: begin
            data_we = 1'b1;
          end
          bwdl_pkg::OP_TICK: begin
            if (period_q != 16'd0) begin
              tick_d = tick_inc;
              if (tick_inc >= period_q) begin
                tick_d  = '0;
                tpend_d = 1'b1;
              end
            end
          end
          bwdl_pkg::OP_BEGIN: begin
            lctl.clear = 1'b1;
            cyc_d   = '0;
            exit_d  = '0;
            tick_d  = '0;
            tpend_d = 1'b0;
          end
          bwdl_pkg::OP_BUS: begin
            state_d = bwdl_pkg::ST_DECIDE;
            if (valid_q) begin
              lba_d = addr_q;
              if (rd_q) begin
                rdat_d = data_rd;
                if ((attr_rd & bwdl_pkg::AttrUninit & exit_en_q) != 8'd0)
                  exit_d = exit_d | bwdl_pkg::AttrUninit;
                if ((attr_rd & bwdl_pkg::AttrBp) != 8'd0)
                  exit_d = exit_d | bwdl_pkg::AttrBp;
              end else begin
                lctl.search = 1'b1;
                state_d = bwdl_pkg::ST_SCAN;
              end
            end
          end
          default: ;  // unknown operations only acknowledge
        endcase
      end
      bwdl_pkg::ST_SCAN: begin
        if (lstat.done) state_d = bwdl_pkg::ST_COMMIT;
      end
      bwdl_pkg::ST_COMMIT: begin
        // store read data is stable: address held and no write since
        lctl.commit = 1'b1;
        if ((attr_rd & bwdl_pkg::AttrRo & exit_en_q) != 8'd0) begin
          exit_d = exit_q | bwdl_pkg::AttrRo;
        end else begin
          attr_we = 1'b1;
          attr_wd = attr_rd & ~bwdl_pkg::AttrUninit;
          data_we = 1'b1;
        end
        state_d = bwdl_pkg::ST_DECIDE;
      end
      bwdl_pkg::ST_DECIDE: begin
        cyc_d = cyc_q + 16'd1;
        if (tpend_q || fill >= CntW'(LogDepth) || exit_q != 8'd0) begin
          if (tpend_q) tpend_d = 1'b0;
          else tick_d = '0;
          // prime the log read port with the first entry
          ridx_d  = '0;
          state_d = bwdl_pkg::ST_REPORT;
        end else begin
          state_d = bwdl_pkg::ST_ACK;
        end
      end
      bwdl_pkg::ST_REPORT: begin
        result_valid_o = 1'b1;
        kind_o         = 1'b1;
        last_o         = rep_done;
        if (fill != CntW'(0)) begin
          entry_valid_o   = 1'b1;
          entry_address_o = 16'(log_a);
          entry_data_o    = log_v;
        end
        if (rep_done) begin
          lctl.clear = 1'b1;
          cyc_d      = '0;
          state_d    = bwdl_pkg::ST_IDLE;
        end else begin
          ridx_d = ridx_q + 1'b1;
        end
      end
      bwdl_pkg::ST_ACK: begin
        result_valid_o = 1'b1;
        state_d        = bwdl_pkg::ST_IDLE;
      end
      default: state_d = bwdl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    read_data_o      = rdat_q;
    exit_code_o      = exit_q;
    report_address_o = 16'(lba_q);
    cycle_total_o    = cyc_q;
    log_count_o      = 7'(fill);
  end
endmodule
